// ===== src/mmss_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multi-mode sample smoother package
// Shared widths, mode codes, configuration indexes and the cell interface.
// ---------------------------------------------------------------------------
package mmss_pkg;
  localparam int WINDOW_MAX  = 16;
  localparam int SAMPLE_BITS = 12;
  localparam int POS_BITS    = $clog2(WINDOW_MAX);
  localparam int SIZE_BITS   = 5;
  localparam int OUT_BITS    = 20;
  localparam int ALPHA_BITS  = 17;
  localparam int ERR_BITS    = 18;
  localparam int SUM_BITS    = SAMPLE_BITS + POS_BITS + 1;
  localparam int CNT_BITS    = POS_BITS + 1;

  localparam logic [ALPHA_BITS-1:0] ONE_Q16   = 17'd65536;
  localparam logic [ALPHA_BITS-1:0] NOISE_Q16 = 17'd6554;
  localparam logic [ERR_BITS-1:0]   ERR_MAX   = 18'd262143;

  typedef enum logic [2:0] {
    MODE_EXP    = 3'd0,
    MODE_AVG    = 3'd1,
    MODE_MEDIAN = 3'd2,
    MODE_KALMAN = 3'd3,
    MODE_COMB   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_ALPHA  = 2'd1,
    REG_WINDOW = 2'd2
  } reg_idx_t;

  // Control handed along the cell row.
  typedef struct packed {
    logic                   clear;  // window size change
    logic                   shift;  // rotate entries one cell
    logic                   write;  // write at position
    logic [POS_BITS-1:0]    pos;
    logic [SAMPLE_BITS-1:0] value;
  } cell_ctrl_t;

  function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] v);
    logic [SIZE_BITS-1:0] r;
    r = v;
    if (v == '0) r = SIZE_BITS'(1);
    else if (v > SIZE_BITS'(WINDOW_MAX)) r = SIZE_BITS'(WINDOW_MAX);
    return r;
  endfunction
endpackage

// ===== src/mmss_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stream channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ---------------------------------------------------------------------------
interface mmss_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

interface mmss_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] filtered_value;
  modport source (output valid, filtered_value, input ready);
  modport sink (input valid, filtered_value, output ready);
endinterface

interface mmss_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/mmss_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Window cell
// One window entry; takes its neighbour's entry when the row rotates.
// ---------------------------------------------------------------------------
module mmss_cell
  import mmss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctrl_t             ctrl,
  input  logic [POS_BITS-1:0]    my_index,
  input  logic [SAMPLE_BITS-1:0] from_next,
  output logic [SAMPLE_BITS-1:0] entry
);
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      entry <= '0;
    end else if (ctrl.write && ctrl.pos == my_index) begin
      entry <= ctrl.value;
    end else if (ctrl.shift) begin
      entry <= from_next;
    end
  end
endmodule

// ===== src/mmss_window.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Window row
// A ring of cells; a full rotation streams every entry past cell zero.
// ---------------------------------------------------------------------------
module mmss_window
  import mmss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctrl_t             ctrl,
  output logic [SAMPLE_BITS-1:0] head
);
  logic [SAMPLE_BITS-1:0] entries [WINDOW_MAX];

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    mmss_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .my_index (POS_BITS'(g)),
      .from_next(entries[(g + 1) % WINDOW_MAX]),
      .entry    (entries[g])
    );
  end

  assign head = entries[0];
endmodule

// ===== src/mmss_divider.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Restoring divider
// Unsigned 34-by-19 division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mmss_divider
  import mmss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] dividend,
  input  logic [18:0] divisor,
  output logic        done,
  output logic [33:0] quotient
);
  logic [5:0]  count;
  logic [18:0] rem;
  logic [33:0] quo;
  logic [19:0] trial;
  logic [20:0] diff;
  logic        busy;

  assign trial = {rem, quo[33]};
  assign diff  = {1'b0, trial} - {2'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'd34;
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!diff[20]) begin
        rem <= diff[18:0];
      end else begin
        rem <= trial[18:0];
      end
      quo <= {quo[32:0], ~diff[20]};
    end
  end

  assign quotient = quo;
endmodule

// ===== src/multi_mode_sample_smoother.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multi-mode sample smoother
// Smooths 12-bit samples into Q12.8 by exponential, average, median,
// Kalman or combined filtering; other mode codes repeat the last output.
// ---------------------------------------------------------------------------
// Usage:
// Samples arrive on the in channel, one result per sample leaves on the out
// channel, and configuration writes (mode, alpha, window size) arrive on the
// cfg channel, which is always ready. Write configuration only while idle.
// The block handles one sample at a time. The windows are rows of cells that
// rotate once per pass, so every entry streams past one adder and compare.
// Exponential mode blends in the BLEND1 and BLEND2 states; average mode
// scans the window and then runs the divider; median mode makes one full
// rotation per rank candidate; Kalman mode runs the divider for the gain;
// combined mode runs median, blend and average in turn. A result is held in
// an output register until its transfer, and the next sample is taken only
// once that transfer has happened. Reset clears both windows, the positions
// and the filter state. A change of effective window size clears both
// windows likewise. A stalled receiver holds the result; no sample is taken
// while a previous result still waits.
// ---------------------------------------------------------------------------
module multi_mode_sample_smoother
  import mmss_pkg::*;
(
  input logic        clk,
  input logic        rst,
  mmss_in_if.sink    in_ch,
  mmss_out_if.source out_ch,
  mmss_cfg_if.sink   cfg
);
  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_DISP   = 10'b0000000010,
    ST_MSCAN  = 10'b0000000100,
    ST_BLEND1 = 10'b0000001000,
    ST_BLEND2 = 10'b0000010000,
    ST_ASCAN  = 10'b0000100000,
    ST_DIV    = 10'b0001000000,
    ST_KAL1   = 10'b0010000000,
    ST_KAL2   = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_t;

  state_t state;
  logic [2:0]             mode;
  logic [ALPHA_BITS-1:0]  alpha_reg;
  logic [SIZE_BITS-1:0]   win_reg;
  logic [SIZE_BITS-1:0]   n;
  logic [POS_BITS-1:0]    wpos, apos;
  logic [OUT_BITS-1:0]    last_output, kal_est;
  logic [ERR_BITS-1:0]    kal_err;
  logic [SAMPLE_BITS-1:0] x;
  logic                   use_avg_win;   // scan the average window
  logic                   div_kal;       // divider serves Kalman

  // Scan bookkeeping.
  logic [CNT_BITS-1:0]    rot;           // steps taken in the rotation
  logic [CNT_BITS-1:0]    cand;          // median candidate index
  logic [SAMPLE_BITS-1:0] cval;          // candidate being ranked
  logic [SAMPLE_BITS-1:0] nval;          // candidate for the next pass
  logic [CNT_BITS-1:0]    less_cnt, leq_cnt;
  logic [SUM_BITS-1:0]    sum;
  logic [OUT_BITS-1:0]    value;         // result presented on the out channel

  // Blend arithmetic: combinational clamped alpha, registered products and input.
  logic [ALPHA_BITS-1:0]  alpha_eff;
  logic [36:0]            prod_a, prod_b;
  logic [OUT_BITS-1:0]    blend_in;

  // Kalman registers.
  logic [ERR_BITS-1:0]    kerr1;
  logic [ALPHA_BITS-1:0]  gain;
  logic [OUT_BITS-1:0]    kdiff;
  logic                   kneg;

  // Divider.
  logic        div_start, div_done;
  logic [33:0] div_dividend, div_q;
  logic [18:0] div_divisor;

  // Windows.
  cell_ctrl_t sctrl, actrl;
  logic [SAMPLE_BITS-1:0] shead, ahead, head;
  logic        cfg_clear;
  logic [SIZE_BITS-1:0] new_size;

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = (state == ST_IDLE) && !out_ch.valid;
  assign n           = eff_size(win_reg);
  assign new_size    = eff_size(cfg.data[SIZE_BITS-1:0]);
  assign cfg_clear   = cfg.valid && cfg.index == REG_WINDOW && new_size != n;
  assign alpha_eff   = (alpha_reg > ONE_Q16) ? ONE_Q16 : alpha_reg;
  assign head        = use_avg_win ? ahead : shead;

  // Full ring rotation is WINDOW_MAX steps; only the first n entries count.
  logic rotating;
  assign rotating = (state == ST_MSCAN) || (state == ST_ASCAN);

  always_comb begin
    sctrl = '0;
    actrl = '0;
    sctrl.clear = cfg_clear;
    actrl.clear = cfg_clear;
    sctrl.shift = rotating && !use_avg_win;
    actrl.shift = rotating && use_avg_win;
    if (state == ST_DISP && (mode == MODE_AVG || mode == MODE_MEDIAN ||
                             mode == MODE_COMB)) begin
      sctrl.write = 1'b1;
      sctrl.pos   = wpos;
      sctrl.value = x;
    end
    if (state == ST_BLEND2) begin
      actrl.write = 1'b1;
      actrl.pos   = apos;
      actrl.value = 12'((prod_a + prod_b) >> 24);
    end
  end

  mmss_window u_swin (.clk(clk), .rst(rst), .ctrl(sctrl), .head(shead));
  mmss_window u_awin (.clk(clk), .rst(rst), .ctrl(actrl), .head(ahead));

  mmss_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_q)
  );

  // Positions advance modulo n.
  function automatic logic [POS_BITS-1:0] adv(input logic [POS_BITS-1:0] p,
                                              input logic [SIZE_BITS-1:0] sz);
    logic [SIZE_BITS-1:0] q;
    q = {1'b0, p} + SIZE_BITS'(1);
    return (q >= sz) ? '0 : q[POS_BITS-1:0];
  endfunction

  logic in_win;
  assign in_win = {1'b0, rot} < {1'b0, n};

  // Rank counts including the entry at the head in this step.
  logic capture, rank;
  logic [CNT_BITS-1:0] less_now, leq_now;
  assign capture  = in_win && rot == cand;
  assign rank     = in_win && cand != '0;
  assign less_now = less_cnt + CNT_BITS'(rank && head < cval);
  assign leq_now  = leq_cnt + CNT_BITS'(rank && head <= cval);

  logic [CNT_BITS-1:0] half;
  assign half = CNT_BITS'(n >> 1);

  logic [ERR_BITS:0] err_sum;
  assign err_sum = {1'b0, kal_err} + {2'b0, NOISE_Q16};

  logic [OUT_BITS-1:0] xq;
  assign xq = {x, 8'd0};

  logic [37:0] kcorr_full;
  assign kcorr_full = gain * kdiff;

  logic [34:0] kerr_full;
  assign kerr_full = kerr1 * (ONE_Q16 - gain);

  // The divider starts after the last scan step or once the Kalman error is set.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= (state == ST_ASCAN && rot == CNT_BITS'(WINDOW_MAX - 1)) ||
                   state == ST_KAL1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      mode        <= MODE_EXP;
      alpha_reg   <= 17'd6554;
      win_reg     <= 5'd5;
      wpos        <= '0;
      apos        <= '0;
      last_output <= '0;
      kal_est     <= '0;
      kal_err     <= 18'd65536;
      out_ch.valid <= 1'b0;
      use_avg_win <= 1'b0;
      div_kal     <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_MODE:   mode <= cfg.data[2:0];
          REG_ALPHA:  alpha_reg <= cfg.data;
          REG_WINDOW: begin
            win_reg <= cfg.data[SIZE_BITS-1:0];
            if (cfg_clear) begin
              wpos <= '0;
              apos <= '0;
            end
          end
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            x     <= in_ch.sample;
            state <= ST_DISP;
          end
        end
        ST_DISP: begin
          rot  <= '0;
          cand <= '0;
          less_cnt <= '0;
          leq_cnt  <= '0;
          sum  <= '0;
          use_avg_win <= 1'b0;
          priority case (mode)
            MODE_EXP: begin
              blend_in <= xq;
              state    <= ST_BLEND1;
            end
            MODE_AVG: begin
              wpos  <= adv(wpos, n);
              state <= ST_ASCAN;
            end
            MODE_MEDIAN, MODE_COMB: begin
              wpos  <= adv(wpos, n);
              state <= ST_MSCAN;
            end
            MODE_KALMAN: begin
              kerr1 <= (err_sum > {1'b0, ERR_MAX}) ? ERR_MAX : err_sum[ERR_BITS-1:0];
              state <= ST_KAL1;
            end
            default: begin
              value <= last_output;
              state <= ST_DONE;
            end
          endcase
        end
        ST_MSCAN: begin
          // On step rot the head holds entry rot. Pass k ranks entry k-1,
          // captured in the previous pass, and captures entry k for the next.
          if (capture) nval <= head;
          if (rot == CNT_BITS'(WINDOW_MAX - 1)) begin
            rot      <= '0;
            cval     <= capture ? head : nval;
            less_cnt <= '0;
            leq_cnt  <= '0;
          end else begin
            rot      <= rot + CNT_BITS'(1);
            less_cnt <= less_now;
            leq_cnt  <= leq_now;
          end
        end
        ST_BLEND1: begin
          prod_a <= alpha_eff * blend_in;
          prod_b <= (ONE_Q16 - alpha_eff) * last_output;
          state  <= ST_BLEND2;
        end
        ST_BLEND2: begin
          blend_in <= 20'((prod_a + prod_b) >> 16);
          if (mode == MODE_COMB) begin
            apos        <= adv(apos, n);
            use_avg_win <= 1'b1;
            rot   <= '0;
            sum   <= '0;
            state <= ST_ASCAN;
          end else begin
            value <= 20'((prod_a + prod_b) >> 16);
            state <= ST_DONE;
          end
        end
        ST_ASCAN: begin
          if (in_win) sum <= sum + SUM_BITS'(head);
          rot <= rot + CNT_BITS'(1);
          if (rot == CNT_BITS'(WINDOW_MAX - 1)) begin
            div_kal      <= 1'b0;
            state        <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (div_kal) begin
              gain  <= div_q[ALPHA_BITS-1:0];
              kneg  <= xq < kal_est;
              kdiff <= (xq < kal_est) ? kal_est - xq : xq - kal_est;
              state <= ST_KAL2;
            end else begin
              value <= div_q[OUT_BITS-1:0];
              state <= ST_DONE;
            end
          end
        end
        ST_KAL1: begin
          div_kal   <= 1'b1;
          state     <= ST_DIV;
        end
        ST_KAL2: begin
          if (kneg) begin
            value <= (kcorr_full[37:16] > 22'(kal_est)) ? '0 :
                     kal_est - kcorr_full[35:16];
          end else begin
            value <= (23'(kal_est) + 23'(kcorr_full[37:16]) > 23'hFFFFF) ?
                     20'hFFFFF : kal_est + kcorr_full[35:16];
          end
          kal_err <= (kerr_full[34:16] > 19'(ERR_MAX)) ? ERR_MAX :
                     kerr_full[ERR_BITS+15:16];
          state <= ST_DONE;
        end
        ST_DONE: begin
          last_output  <= value;
          if (mode == MODE_KALMAN) kal_est <= value;
          out_ch.valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase

      // Median selection: at the end of each rank pass, test the candidate.
      if (state == ST_MSCAN && rot == CNT_BITS'(WINDOW_MAX - 1)) begin
        if (cand != '0 && less_now <= half && leq_now > half) begin
          if (mode == MODE_COMB) begin
            blend_in    <= {cval, 8'd0};
            last_output <= {cval, 8'd0};
            state       <= ST_BLEND1;
          end else begin
            value <= {cval, 8'd0};
            state <= ST_DONE;
          end
        end
        cand <= cand + CNT_BITS'(1);
      end
    end
  end

  always_comb begin
    if (div_kal) begin
      div_dividend = {kerr1, 16'd0};
      div_divisor  = 19'(kerr1) + 19'(NOISE_Q16);
    end else begin
      div_dividend = 34'(sum) << 8;
      div_divisor  = 19'(n);
    end
  end

  assign out_ch.filtered_value = value;

  // In combined mode last_output takes the median before the blend, so the
  // blend starts from it; ST_DONE then writes the final result.

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |=> out_ch.valid) else $error("result not presented");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("sample taken while result waits");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.filtered_value))
    else $error("result changed while stalled");
  a_pos: assert property (@(posedge clk) disable iff (rst)
    {1'b0, wpos} < n && {1'b0, apos} < n || $past(cfg.valid))
    else $error("window position out of range");
endmodule

// ===== dv/tb_multi_mode_sample_smoother.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multi-mode sample smoother testbench
// Sends samples with random gaps and back-pressure, reconfigures the block
// between phases while it is idle, and checks every result against an
// in-bench predictor of all five filters or a typed value compared with it.
// ---------------------------------------------------------------------------
module tb_multi_mode_sample_smoother;
  import mmss_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mmss_in_if  in_ch ();
  mmss_out_if out_ch ();
  mmss_cfg_if cfg ();

  multi_mode_sample_smoother i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg    (cfg.sink)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state, mirroring the block's registers and windows.
  logic [2:0]              sm_mode;
  logic [ALPHA_BITS-1:0]   sm_alpha;
  logic [SIZE_BITS-1:0]    sm_size;
  logic [SAMPLE_BITS-1:0]  raw_win [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0]  avg_win [WINDOW_MAX];
  int unsigned             raw_pos, avg_pos;
  logic [OUT_BITS-1:0]     prev_out;
  logic [OUT_BITS-1:0]     kal_est;
  logic [ERR_BITS-1:0]     kal_err;

  logic [OUT_BITS-1:0]     expected_values[$];
  int                      errors = 0;
  int                      idle_cycles = 0;
  bit                      drive_done = 1'b0;

  function automatic int unsigned win_len(logic [SIZE_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > WINDOW_MAX) return WINDOW_MAX;
    return v;
  endfunction

  function automatic logic [OUT_BITS-1:0] exp_blend(logic [SAMPLE_BITS-1:0] x);
    longint unsigned a, r;
    a = (sm_alpha > ONE_Q16) ? 65536 : sm_alpha;
    r = (a * (longint'(x) << 8) + (65536 - a) * longint'(prev_out)) >> 16;
    return r[OUT_BITS-1:0];
  endfunction

  function automatic logic [OUT_BITS-1:0] window_mean(bit use_avg, int unsigned n);
    longint unsigned s;
    s = 0;
    for (int i = 0; i < n; i++) s += use_avg ? avg_win[i] : raw_win[i];
    s = (s << 8) / n;
    return s[OUT_BITS-1:0];
  endfunction

  // Upper median: entry n/2 of the first n samples in ascending order.
  function automatic logic [OUT_BITS-1:0] window_median(int unsigned n);
    logic [SAMPLE_BITS-1:0] t [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] v;
    for (int i = 0; i < n; i++) t[i] = raw_win[i];
    for (int i = 1; i < n; i++)
      for (int j = i; j > 0 && t[j-1] > t[j]; j--) begin
        v = t[j]; t[j] = t[j-1]; t[j-1] = v;
      end
    return {t[n/2], 8'd0};
  endfunction

  function automatic void push_raw(logic [SAMPLE_BITS-1:0] v, int unsigned n);
    if (raw_pos >= n) raw_pos = 0;
    raw_win[raw_pos] = v;
    raw_pos = (raw_pos + 1 >= n) ? 0 : raw_pos + 1;
  endfunction

  function automatic void push_avg(logic [SAMPLE_BITS-1:0] v, int unsigned n);
    if (avg_pos >= n) avg_pos = 0;
    avg_win[avg_pos] = v;
    avg_pos = (avg_pos + 1 >= n) ? 0 : avg_pos + 1;
  endfunction

  function automatic logic [OUT_BITS-1:0] kalman_step(logic [SAMPLE_BITS-1:0] x);
    longint unsigned e, g, c, xv, est;
    e = longint'(kal_err) + 6554;
    if (e > 262143) e = 262143;
    g = (e << 16) / (e + 6554);
    xv = longint'(x) << 8;
    est = kal_est;
    if (xv >= est) begin
      c = (g * (xv - est)) >> 16;
      est += c;
    end else begin
      c = (g * (est - xv)) >> 16;
      est = (c > est) ? 0 : est - c;
    end
    if (est > 20'hFFFFF) est = 20'hFFFFF;
    e = (e * (65536 - g)) >> 16;
    if (e > 262143) e = 262143;
    kal_est = est[OUT_BITS-1:0];
    kal_err = e[ERR_BITS-1:0];
    return kal_est;
  endfunction

  function automatic logic [OUT_BITS-1:0] smooth_sample(logic [SAMPLE_BITS-1:0] x);
    int unsigned n;
    logic [OUT_BITS-1:0] r;
    n = win_len(sm_size);
    case (sm_mode)
      MODE_EXP: r = exp_blend(x);
      MODE_AVG: begin
        push_raw(x, n);
        r = window_mean(1'b0, n);
      end
      MODE_MEDIAN: begin
        push_raw(x, n);
        r = window_median(n);
      end
      MODE_KALMAN: r = kalman_step(x);
      MODE_COMB: begin
        push_raw(x, n);
        prev_out = window_median(n);
        r = exp_blend(prev_out[19:8]);
        push_avg(r[19:8], n);
        r = window_mean(1'b1, n);
      end
      default: r = prev_out;
    endcase
    prev_out = r;
    return r;
  endfunction

  function automatic void shadow_reset();
    sm_mode  = MODE_EXP;
    sm_alpha = 17'd6554;
    sm_size  = 5'd5;
    foreach (raw_win[i]) raw_win[i] = '0;
    foreach (avg_win[i]) avg_win[i] = '0;
    raw_pos  = 0;
    avg_pos  = 0;
    prev_out = '0;
    kal_est  = '0;
    kal_err  = 18'd65536;
  endfunction

  function automatic void shadow_write(reg_idx_t idx, logic [16:0] d);
    case (idx)
      REG_MODE:  sm_mode = d[2:0];
      REG_ALPHA: sm_alpha = d;
      REG_WINDOW: begin
        if (win_len(d[4:0]) != win_len(sm_size)) begin
          foreach (raw_win[i]) raw_win[i] = '0;
          foreach (avg_win[i]) avg_win[i] = '0;
          raw_pos = 0;
          avg_pos = 0;
        end
        sm_size = d[4:0];
      end
      default: ;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one; some stretches with none.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [16:0] d);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    shadow_write(idx, d);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // One sample transfer; when a fixed result is given it is checked against
  // the predictor as well, so a typed-in value that drifts from the model is reported.
  task automatic send_sample(logic [SAMPLE_BITS-1:0] x, bit has_fixed,
                             logic [OUT_BITS-1:0] fixed);
    logic [OUT_BITS-1:0] p;
    in_ch.valid  = 1'b1;
    in_ch.sample = x;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = smooth_sample(x);
    if (has_fixed && p != fixed)
      $display("%0t: table entry disagrees for sample %0d: expected %0d, predicted %0d",
               $time, x, fixed, p);
    expected_values.push_back(has_fixed ? fixed : p);
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (gap_len()) @(negedge clk);
  endtask

  // Wait until every expected result has been transferred, then let the
  // block settle before configuration is touched.
  task automatic drain();
    while (expected_values.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Directed table: operation codes, register write or sample, and a typed
  // result where it is plain from the model.
  typedef enum logic [1:0] { ROW_CFG, ROW_SAMPLE, ROW_FIXED } row_kind_t;
  typedef struct {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [16:0] val;
    logic [19:0] res;
  } stim_row_t;

  stim_row_t rows[$];

  function automatic void add_row(row_kind_t k, reg_idx_t i, logic [16:0] v,
                                  logic [19:0] r);
    stim_row_t s;
    s.kind = k; s.idx = i; s.val = v; s.res = r;
    rows.push_back(s);
  endfunction

  // Output side: random back-pressure and the scoreboard check.
  int out_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap      <= out_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_ch.valid && out_ch.ready) out_gap <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %0d",
                 $time, out_ch.filtered_value);
        errors++;
      end else begin
        if (out_ch.filtered_value !== expected_values[0]) begin
          $display("%0t: filtered_value mismatch: expected %0d, actual %0d",
                   $time, expected_values[0], out_ch.filtered_value);
          errors++;
        end
        void'(expected_values.pop_front());
      end
    end
  end

  // Watchdog: counts cycles without any transfer on any channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready) || rst)
      idle_cycles <= 0;
    else if (!drive_done || expected_values.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int burst;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    cfg.valid    = 1'b0;
    cfg.index    = REG_MODE;
    cfg.data     = '0;
    shadow_reset();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // After reset: exponential with alpha 6554.
    add_row(ROW_FIXED,  REG_MODE,   17'd0,     20'd0);
    add_row(ROW_SAMPLE, REG_MODE,   17'd4095,  20'd0);
    add_row(ROW_CFG,    REG_ALPHA,  17'd65536, 20'd0);
    add_row(ROW_FIXED,  REG_MODE,   17'd4095,  20'hFFF00);
    add_row(ROW_CFG,    REG_ALPHA,  17'h1FFFF, 20'd0);   // alpha clamps to one
    add_row(ROW_FIXED,  REG_MODE,   17'd1,     20'h00100);
    add_row(ROW_CFG,    REG_ALPHA,  17'd0,     20'd0);   // output frozen
    add_row(ROW_FIXED,  REG_MODE,   17'd4095,  20'h00100);
    add_row(ROW_CFG,    REG_WINDOW, 17'd0,     20'd0);   // size zero acts as one
    add_row(ROW_CFG,    REG_MODE,   MODE_AVG,  20'd0);
    add_row(ROW_FIXED,  REG_MODE,   17'd4095,  20'hFFF00);
    add_row(ROW_CFG,    REG_WINDOW, 17'd31,    20'd0);   // above max acts as 16
    add_row(ROW_SAMPLE, REG_MODE,   17'd4095,  20'd0);
    add_row(ROW_CFG,    REG_MODE,   MODE_MEDIAN, 20'd0);
    add_row(ROW_FIXED,  REG_MODE,   17'd4095,  20'd0);   // zeros still dominate
    add_row(ROW_CFG,    REG_MODE,   MODE_KALMAN, 20'd0);
    add_row(ROW_SAMPLE, REG_MODE,   17'd4095,  20'd0);
    add_row(ROW_SAMPLE, REG_MODE,   17'd0,     20'd0);
    add_row(ROW_CFG,    REG_MODE,   MODE_COMB, 20'd0);
    add_row(ROW_CFG,    REG_ALPHA,  17'd30000, 20'd0);
    add_row(ROW_SAMPLE, REG_MODE,   17'd2730,  20'd0);
    add_row(ROW_SAMPLE, REG_MODE,   17'd1365,  20'd0);
    add_row(ROW_CFG,    REG_MODE,   17'd7,     20'd0);   // unknown mode holds
    add_row(ROW_SAMPLE, REG_MODE,   17'd1234,  20'd0);
    add_row(ROW_CFG,    REG_MODE,   17'd5,     20'd0);
    add_row(ROW_SAMPLE, REG_MODE,   17'd4095,  20'd0);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_sample(rows[i].val[11:0], rows[i].kind == ROW_FIXED, rows[i].res);
      end
    end

    // Random phases: a fresh setting, then a burst of samples.
    for (int sent = 0; sent < 1400; sent += burst) begin
      drain();
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_WINDOW, 17'($urandom_range(0, 3) == 0 ?
                  $urandom_range(0, 31) : $urandom_range(1, 6)));
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: write_reg(REG_ALPHA, 17'd0);
          1: write_reg(REG_ALPHA, 17'd65536);
          2: write_reg(REG_ALPHA, 17'h1FFFF);
          default: write_reg(REG_ALPHA, 17'($urandom_range(0, 65536)));
        endcase
      end
      write_reg(REG_MODE, 17'($urandom_range(0, 19) == 0 ?
                $urandom_range(5, 7) : $urandom_range(0, 4)));
      burst = $urandom_range(10, 60);
      for (int k = 0; k < burst; k++)
        send_sample(12'($urandom_range(0, 3) == 0 ?
                    ($urandom_range(0, 1) ? 4095 : 0) : $urandom), 1'b0, '0);
    end

    drain();
    drive_done = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_values.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
